### sv/duiv_pkg.sv
// ----------------------------------------------------------------------------
// duiv_pkg
// Types and constant tables for the image data URL validator.
// ----------------------------------------------------------------------------
package duiv_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_SUBTYPE = 3'd1,
    PH_ENC     = 3'd2,
    PH_DATA    = 3'd3,
    PH_FAIL    = 3'd4
  } phase_t;

  localparam int         N_SUB        = 9;
  localparam logic [3:0] PREFIX_LEN   = 4'd11;
  localparam logic [3:0] ENC_LEN      = 4'd6;
  localparam logic [3:0] IDX_MAX      = 4'd15;
  localparam logic [8:0] ALL_SUBTYPES = 9'h1FF;

  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_COMMA = ",";

  localparam logic [7:0] LEAD_TEXT [11] =
    '{"d", "a", "t", "a", ":", "i", "m", "a", "g", "e", "/"};

  localparam logic [7:0] ENC_TEXT [6] = '{"b", "a", "s", "e", "6", "4"};

  // png, jpeg, jpg, gif, webp, bmp, svg+xml, tiff, x-icon
  localparam logic [7:0] SUB_NAME [N_SUB][8] = '{
    '{"p", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"j", "p", "e", "g", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"j", "p", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "e", "b", "p", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "m", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "v", "g", "+", "x", "m", "l", 8'h00},
    '{"t", "i", "f", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"x", "-", "i", "c", "o", "n", 8'h00, 8'h00}
  };

  localparam logic [3:0] SUB_LEN [N_SUB] =
    '{4'd3, 4'd4, 4'd3, 4'd3, 4'd4, 4'd3, 4'd7, 4'd4, 4'd6};

  typedef struct packed {
    phase_t     phase;
    logic [3:0] sect_idx;
    logic [8:0] cands;
    logic [1:0] len_mod4;
    logic       data_seen;
    logic       base64;
  } duiv_state_t;

  localparam duiv_state_t STATE_RESET = '{
    phase:     PH_PREFIX,
    sect_idx:  4'd0,
    cands:     ALL_SUBTYPES,
    len_mod4:  2'd0,
    data_seen: 1'b0,
    base64:    1'b0
  };

  function automatic logic is_b64(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
           (b >= "0" && b <= "9") || b == "+" || b == "/" || b == "=";
  endfunction

endpackage

### sv/duiv_step.sv
// ----------------------------------------------------------------------------
// duiv_step
// Per-byte state update and verdict for the image data URL validator.
// ----------------------------------------------------------------------------
module duiv_step (
  input  duiv_pkg::duiv_state_t cur,
  input  logic [7:0]            url_byte,
  output duiv_pkg::duiv_state_t nxt,
  output logic                  verdict
);

  logic [8:0] keep;

  always_comb begin
    nxt  = cur;
    keep = '0;
    unique case (cur.phase)
      duiv_pkg::PH_PREFIX: begin
        if (cur.sect_idx < duiv_pkg::PREFIX_LEN &&
            url_byte == duiv_pkg::LEAD_TEXT[cur.sect_idx]) begin
          if (cur.sect_idx == duiv_pkg::PREFIX_LEN - 4'd1) begin
            nxt.phase    = duiv_pkg::PH_SUBTYPE;
            nxt.sect_idx = 4'd0;
            nxt.cands    = duiv_pkg::ALL_SUBTYPES;
          end else begin
            nxt.sect_idx = cur.sect_idx + 4'd1;
          end
        end else begin
          nxt.phase = duiv_pkg::PH_FAIL;
        end
      end
      duiv_pkg::PH_SUBTYPE: begin
        if (url_byte == duiv_pkg::CH_SEMI) begin
          for (int i = 0; i < duiv_pkg::N_SUB; i++) begin
            keep[i] = cur.cands[i] && (duiv_pkg::SUB_LEN[i] == cur.sect_idx);
          end
          if (keep == '0) begin
            nxt.phase = duiv_pkg::PH_FAIL;
          end else begin
            nxt.cands    = keep;
            nxt.phase    = duiv_pkg::PH_ENC;
            nxt.sect_idx = 4'd0;
          end
        end else begin
          for (int i = 0; i < duiv_pkg::N_SUB; i++) begin
            keep[i] = cur.cands[i] && (cur.sect_idx < duiv_pkg::SUB_LEN[i]) &&
                      (duiv_pkg::SUB_NAME[i][cur.sect_idx[2:0]] == url_byte);
          end
          nxt.cands = keep;
          if (cur.sect_idx != duiv_pkg::IDX_MAX) begin
            nxt.sect_idx = cur.sect_idx + 4'd1;
          end
        end
      end
      duiv_pkg::PH_ENC: begin
        if (url_byte == duiv_pkg::CH_COMMA) begin
          if (cur.sect_idx == 4'd0) begin
            nxt.base64 = 1'b0;
            nxt.phase  = duiv_pkg::PH_DATA;
          end else if (cur.sect_idx == duiv_pkg::ENC_LEN) begin
            nxt.base64 = 1'b1;
            nxt.phase  = duiv_pkg::PH_DATA;
          end else begin
            nxt.phase = duiv_pkg::PH_FAIL;
          end
          nxt.sect_idx = 4'd0;
        end else if (cur.sect_idx < duiv_pkg::ENC_LEN &&
                     url_byte == duiv_pkg::ENC_TEXT[cur.sect_idx[2:0]]) begin
          nxt.sect_idx = cur.sect_idx + 4'd1;
        end else begin
          nxt.phase = duiv_pkg::PH_FAIL;
        end
      end
      duiv_pkg::PH_DATA: begin
        nxt.data_seen = 1'b1;
        nxt.len_mod4  = cur.len_mod4 + 2'd1;
        if (cur.base64 && !duiv_pkg::is_b64(url_byte)) begin
          nxt.phase = duiv_pkg::PH_FAIL;
        end
      end
      default: begin
        nxt.phase = duiv_pkg::PH_FAIL;
      end
    endcase
  end

  assign verdict = (nxt.phase == duiv_pkg::PH_DATA) && nxt.data_seen &&
                   (!nxt.base64 || nxt.len_mod4 == 2'd0);

endmodule

### sv/data_image_url_validator.sv
// ----------------------------------------------------------------------------
// data_image_url_validator
// Streams a URL one byte per item and flags whether it is an image data URL.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; a stall appears only when a verdict waits.
// Verdict path: the final byte is captured in the input register, and its verdict
//   is written to the result register once no earlier verdict is waiting.
// Reset: synchronous rst_n clears the input and result valids and returns the
//   parse state to prefix matching; the state also resets after every final byte.
module data_image_url_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_url_byte,
  input  logic       in_end_of_url,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_url_valid
);

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  s1_end_r;
  duiv_pkg::duiv_state_t state_r;
  duiv_pkg::duiv_state_t state_nxt;
  logic                  out_valid_r;
  logic                  out_url_valid_r;
  logic                  verdict;
  logic                  proc;
  logic                  out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && (!s1_end_r || out_free);
  assign in_stall = s1_valid_r && !proc;

  duiv_step u_step (
    .cur      (state_r),
    .url_byte (s1_byte_r),
    .nxt      (state_nxt),
    .verdict  (verdict)
  );

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_url_byte;
      s1_end_r  <= in_end_of_url;
    end
    if (proc && s1_end_r) begin
      out_url_valid_r <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= duiv_pkg::STATE_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (proc) begin
        state_r <= s1_end_r ? duiv_pkg::STATE_RESET : state_nxt;
      end
      if (proc && s1_end_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_url_valid = out_url_valid_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_end_r && out_valid_r && out_stall))
    else $error("input stalled without a waiting verdict");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_end_r) |=> out_valid_r)
    else $error("final byte produced no verdict");

  a_end_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_end_r) |=> (state_r == duiv_pkg::STATE_RESET))
    else $error("state not reset after final byte");

  a_data_seen_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.data_seen |->
      (state_r.phase == duiv_pkg::PH_DATA || state_r.phase == duiv_pkg::PH_FAIL))
    else $error("data seen outside data phase");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_url_valid_r)))
    else $error("pending verdict lost or changed");

endmodule
